@@ rtl/sdr_pkg.sv @@
// Shared types, constants and functions of the sharpen, dither and rotate block.
package sdr_pkg;

  localparam int unsigned MaxWidth   = 480;
  localparam int unsigned MaxHeight  = 800;
  localparam int unsigned PhysStride = 800;

  localparam int unsigned ColW  = 9;
  localparam int unsigned RowW  = 10;
  localparam int unsigned AddrW = 19;

  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegOffX   = 3'd2;
  localparam logic [2:0] RegOffY   = 3'd3;
  localparam logic [2:0] RegGain   = 3'd4;

  // One job handed from the front to the back: window taps already chosen
  // for edge replication, plus position data.
  typedef struct packed {
    logic [8:0][23:0] win;
    logic [ColW-1:0]  x;
    logic [RowW-1:0]  y;
    logic             run_last;
    logic             frame_last;
  } job_t;

  typedef struct packed {
    logic [AddrW-1:0] fb_address;
    logic [15:0]      pixel_565;
    logic             run_last;
    logic             frame_last;
  } res_t;

  function automatic logic [3:0] dither_value(input logic [1:0] y, input logic [1:0] x);
    logic [3:0] d;
    case ({y, x})
      4'd0: d = 4'd0;   4'd1: d = 4'd8;   4'd2: d = 4'd2;   4'd3: d = 4'd10;
      4'd4: d = 4'd12;  4'd5: d = 4'd4;   4'd6: d = 4'd14;  4'd7: d = 4'd6;
      4'd8: d = 4'd3;   4'd9: d = 4'd11;  4'd10: d = 4'd1;  4'd11: d = 4'd9;
      4'd12: d = 4'd15; 4'd13: d = 4'd7;  4'd14: d = 4'd13; default: d = 4'd5;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] lim8(input logic signed [19:0] v);
    logic [7:0] r;
    if (v < 0) r = 8'd0;
    else if (v > 20'sd255) r = 8'd255;
    else r = v[7:0];
    return r;
  endfunction

endpackage

@@ rtl/sdr_front.sv @@
// Front part: position counting, line buffers, window and job generation.
module sdr_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [23:0]             px_i,
  input  logic [8:0]              width_i,
  input  logic [9:0]              height_i,
  output logic                    job_valid_o,
  input  logic                    job_ready_i,
  output sdr_pkg::job_t           job_o
);

  logic [23:0] older_mem [sdr_pkg::MaxWidth];
  logic [23:0] newer_mem [sdr_pkg::MaxWidth];

  logic [8:0] col_q, col_d;
  logic [9:0] row_q, row_d;
  logic [8:0] w_m1;
  logic [9:0] h_m1;
  logic [8:0] c;
  logic [9:0] r;
  logic       endc, lastr, acc;

  // Stage 2 (after memory read) registers.
  logic        s2_valid_q;
  logic [23:0] s2_px_q, s2_old_q, s2_new_q;
  logic [8:0]  s2_c_q;
  logic [9:0]  s2_r_q;
  logic        s2_endc_q, s2_lastr_q;
  logic [8:0]  s2_w_q;
  logic [9:0]  s2_h_q;

  logic [8:0][23:0] win_q, win_d;

  // Emission sequencer over up to four jobs per pixel.
  logic        e_busy_q, e_busy_d;
  logic [3:0]  e_mask_q, e_mask_d;
  logic [8:0]  e_c_q;
  logic [9:0]  e_r_q;
  logic [8:0]  e_w_q;
  logic [9:0]  e_h_q;
  logic [8:0][23:0] e_win_q;

  logic [1:0]  sel;
  logic [3:0]  sel_oh, rest;
  logic [3:0]  new_mask;

  always_comb begin
    w_m1 = (width_i == 9'd0) ? 9'd0 :
           (width_i > 9'(sdr_pkg::MaxWidth)) ? 9'(sdr_pkg::MaxWidth - 1) : width_i - 9'd1;
    h_m1 = (height_i == 10'd0) ? 10'd0 :
           (height_i > 10'(sdr_pkg::MaxHeight)) ? 10'(sdr_pkg::MaxHeight - 1)
                                                : height_i - 10'd1;
    c = (col_q > w_m1) ? w_m1 : col_q;
    r = (row_q > h_m1) ? h_m1 : row_q;
    endc  = (c == w_m1);
    lastr = (r == h_m1);
  end

  // Stage 2 can only drain into the sequencer when it is free or finishing.
  logic seq_free;
  logic s2_adv;
  assign seq_free   = !e_busy_q || (job_ready_i && (rest == 4'd0));
  assign s2_adv     = s2_valid_q && seq_free;
  assign in_ready_o = !s2_valid_q || seq_free;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if (endc) begin
        col_d = '0;
        row_d = lastr ? 10'd0 : r + 10'd1;
      end else begin
        col_d = c + 9'd1;
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s2_old_q <= older_mem[c];
      s2_new_q <= newer_mem[c];
      older_mem[c] <= newer_mem[c];
      newer_mem[c] <= px_i;
      s2_px_q <= px_i;
      s2_c_q <= c;
      s2_r_q <= r;
      s2_endc_q <= endc;
      s2_lastr_q <= lastr;
      s2_w_q <= w_m1;
      s2_h_q <= h_m1;
    end
  end

  always_comb begin
    win_d = win_q;
    if (s2_adv) begin
      win_d[0] = win_q[1]; win_d[1] = win_q[2];
      win_d[3] = win_q[4]; win_d[4] = win_q[5];
      win_d[6] = win_q[7]; win_d[7] = win_q[8];
      win_d[2] = s2_old_q; win_d[5] = s2_new_q; win_d[8] = s2_px_q;
    end
  end

  always_comb begin
    new_mask[0] = (s2_r_q != 10'd0) && (s2_c_q != 9'd0);
    new_mask[1] = (s2_r_q != 10'd0) && s2_endc_q;
    new_mask[2] = s2_lastr_q && (s2_c_q != 9'd0);
    new_mask[3] = s2_lastr_q && s2_endc_q;
  end

  always_comb begin
    sel = 2'd0;
    if (e_mask_q[0]) sel = 2'd0;
    else if (e_mask_q[1]) sel = 2'd1;
    else if (e_mask_q[2]) sel = 2'd2;
    else sel = 2'd3;
    sel_oh = 4'd1 << sel;
    rest = e_mask_q & ~sel_oh;
  end

  always_comb begin
    e_busy_d = e_busy_q;
    e_mask_d = e_mask_q;
    if (e_busy_q && job_ready_i) begin
      e_mask_d = rest;
      e_busy_d = (rest != 4'd0);
    end
    if (s2_adv) begin
      e_mask_d = new_mask;
      e_busy_d = (new_mask != 4'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      e_c_q <= s2_c_q;
      e_r_q <= s2_r_q;
      e_w_q <= s2_w_q;
      e_h_q <= s2_h_q;
      e_win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s2_valid_q <= 1'b0;
      e_busy_q <= 1'b0;
      e_mask_q <= '0;
      win_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (acc) s2_valid_q <= 1'b1;
      else if (s2_adv) s2_valid_q <= 1'b0;
      e_busy_q <= e_busy_d;
      e_mask_q <= e_mask_d;
      win_q <= win_d;
    end
  end

  // Row and column tap indexes of the selected job.
  logic [1:0] rt, rm, cl, cm;
  always_comb begin
    if (!sel[1]) begin
      rt = (e_r_q >= 10'd2) ? 2'd0 : 2'd1;
      rm = 2'd1;
    end else begin
      rt = (e_r_q >= 10'd1) ? 2'd1 : 2'd2;
      rm = 2'd2;
    end
    if (!sel[0]) begin
      cl = (e_c_q >= 9'd2) ? 2'd0 : 2'd1;
      cm = 2'd1;
    end else begin
      cl = (e_c_q >= 9'd1) ? 2'd1 : 2'd2;
      cm = 2'd2;
    end
  end

  logic [1:0] rows [3];
  logic [1:0] cols [3];
  always_comb begin
    rows[0] = rt; rows[1] = rm; rows[2] = 2'd2;
    cols[0] = cl; cols[1] = cm; cols[2] = 2'd2;
    job_o.win = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        job_o.win[i*3+j] = e_win_q[4'(rows[i]) * 4'd3 + 4'(cols[j])];
      end
    end
    job_o.x = sel[0] ? e_c_q : e_c_q - 9'd1;
    job_o.y = sel[1] ? e_r_q : e_r_q - 10'd1;
    job_o.run_last = (rest == 4'd0);
    job_o.frame_last = (job_o.x == e_w_q) && (job_o.y == e_h_q);
  end

  assign job_valid_o = e_busy_q;

endmodule

@@ rtl/sdr_fifo.sv @@
// Short queue of jobs between the front and the back.
module sdr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  sdr_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output sdr_pkg::job_t rd_data_o
);

  sdr_pkg::job_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 3'd4);
  assign rd_valid_o = (cnt_q != 3'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
    end
  end

endmodule

@@ rtl/sdr_back.sv @@
// Back part: sharpening, dither, RGB565 packing and address, as a pipeline.
module sdr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  sdr_pkg::job_t job_i,
  input  logic [8:0]    gain_i,
  input  logic [8:0]    offset_x_i,
  input  logic [9:0]    offset_y_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output sdr_pkg::res_t res_o
);

  // Three stages; a stage moves when the one after it is free or moving.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  assign adv3 = !v3_q || res_ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign job_ready_o = adv1;

  // Stage 1: center minus mean per channel.
  logic signed [8:0] hi_d [3];
  logic signed [8:0] hi_q [3];
  logic [7:0] c_q [3];
  logic [7:0] c_d [3];
  logic [11:0] sum;
  logic [ 7:0] mean;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      for (int k = 0; k < 9; k++) sum = sum + 12'(job_i.win[k][23-8*ch -: 8]);
      mean = 8'((24'(sum) * 24'd3641) >> 15);
      c_d[ch] = job_i.win[4][23-8*ch -: 8];
      hi_d[ch] = $signed({1'b0, c_d[ch]}) - $signed({1'b0, mean});
    end
  end

  logic [8:0] x1_q, x2_q;
  logic [9:0] y1_q, y2_q;
  logic rl1_q, fl1_q, rl2_q, fl2_q;
  always_ff @(posedge clk_i) begin
    if (adv1 && job_valid_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        hi_q[ch] <= hi_d[ch];
        c_q[ch] <= c_d[ch];
      end
      x1_q <= job_i.x; y1_q <= job_i.y;
      rl1_q <= job_i.run_last; fl1_q <= job_i.frame_last;
    end
  end

  // Stage 2: multiply by gain, truncate toward zero, clamp.
  logic signed [18:0] prod;
  logic signed [19:0] qv;
  logic [7:0] s_d [3];
  logic [7:0] s_q [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod = hi_q[ch] * $signed({1'b0, gain_i});
      qv = (prod < 0) ? -((-20'(prod)) >>> 8) : (20'(prod) >>> 8);
      s_d[ch] = sdr_pkg::lim8(qv + 20'(c_q[ch]));
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      for (int ch = 0; ch < 3; ch++) s_q[ch] <= s_d[ch];
      x2_q <= x1_q; y2_q <= y1_q; rl2_q <= rl1_q; fl2_q <= fl1_q;
    end
  end

  // Stage 3: dither, pack, address.
  logic [3:0] d;
  logic [7:0] rr, gg, bb;
  logic [sdr_pkg::AddrW-1:0] addr;
  logic [sdr_pkg::AddrW-1:0] colp;
  always_comb begin
    d  = sdr_pkg::dither_value(y2_q[1:0], x2_q[1:0]);
    rr = sdr_pkg::lim8(20'(s_q[0]) + 20'(d >> 1) - 20'sd4);
    gg = sdr_pkg::lim8(20'(s_q[1]) + 20'(d >> 2) - 20'sd2);
    bb = sdr_pkg::lim8(20'(s_q[2]) + 20'(d >> 1) - 20'sd4);
    colp = 19'(sdr_pkg::MaxWidth - 1) - 19'(offset_x_i) - 19'(x2_q);
    addr = 19'(colp * 19'(sdr_pkg::PhysStride)) + 19'(offset_y_i) + 19'(y2_q);
  end
  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      res_o.fb_address <= addr;
      res_o.pixel_565 <= {rr[7:3], gg[7:2], bb[7:3]};
      res_o.run_last <= rl2_q;
      res_o.frame_last <= fl2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= job_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  assign res_valid_o = v3_q;

endmodule

@@ rtl/sharpen_dither_rgb565_rotator.sv @@
// Top level of the sharpen, dither and rotated RGB565 placement block.
//
// Input stream (s_axis_*): one RGB888 pixel per transfer in raster order,
// tdata = red (7:0), green (15:8), blue (23:16). Output stream (m_axis_*):
// tdata = fb_address (18:0), pixel_565 (34:19), zero fill; tlast marks the
// last result caused by one input pixel; tuser marks the final image pixel.
// Each pixel yields zero to four results: outputs trail the input by one
// row and one column, and the last row is flushed as it arrives.
// The front takes one pixel per cycle into the line memories, read once
// per pixel, while its sequencer can take the jobs; the sequencer emits
// them one per cycle while the queue accepts, so throughput is one pixel
// per cycle except at row ends and on the last row, where up to four jobs
// per pixel go out in turn. A four-entry job queue and a three-stage back
// pipeline (mean, gain multiply, dither and address) decouple the sides.
// When the receiver stalls, the pipeline holds and the queue fills, then
// input stops. Reset clears counters, window and control; the registers
// return to width 480, height 800, offsets 0 and gain 100. Line memory
// contents are undefined until written and need no clearing.
// Configuration is written through cfg_we_i, cfg_addr_i, cfg_wdata_i.
module sharpen_dither_rgb565_rotator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // fb_address, pixel_565, zero fill
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // frame_last
);

  logic [8:0] width_q, offx_q, gain_q;
  logic [9:0] height_q, offy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 9'd480;
      height_q <= 10'd800;
      offx_q <= 9'd0;
      offy_q <= 10'd0;
      gain_q <= 9'd100;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sdr_pkg::RegWidth:  width_q  <= cfg_wdata_i[8:0];
        sdr_pkg::RegHeight: height_q <= cfg_wdata_i;
        sdr_pkg::RegOffX:   offx_q   <= cfg_wdata_i[8:0];
        sdr_pkg::RegOffY:   offy_q   <= cfg_wdata_i;
        sdr_pkg::RegGain:   gain_q   <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // The pixel word keeps red in the top byte, as the window taps expect.
  logic [23:0] px;
  assign px = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  logic f_valid, f_ready, q_valid, q_ready;
  sdr_pkg::job_t f_job, q_job;
  sdr_pkg::res_t res;

  sdr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .px_i(px),
    .width_i(width_q), .height_i(height_q),
    .job_valid_o(f_valid), .job_ready_i(f_ready), .job_o(f_job)
  );

  sdr_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_job),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_job)
  );

  sdr_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .gain_i(gain_q), .offset_x_i(offx_q), .offset_y_i(offy_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {5'd0, res.pixel_565, res.fb_address};
  assign m_axis_tlast = res.run_last;
  assign m_axis_tuser = res.frame_last;

endmodule
